### src/lifo_stack_with_reverse_defines.svh
// Assertion helpers for the stack checker.
`ifndef LIFO_STACK_WITH_REVERSE_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lsr_pkg.sv
package lsr_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_REV  = 2'd2;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_UDF = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef struct packed {
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
  } mem_req_t;

endpackage

### src/lsr_ram.sv
module lsr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/lsr_ctrl.sv
module lsr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [lsr_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsr_pkg::CNT_W-1:0]     cfg_capacity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lsr_pkg::DATA_WIDTH-1:0] out_pop_value,
  output logic [1:0]                    out_status,
  output logic [lsr_pkg::CNT_W-1:0]     out_count,
  output lsr_pkg::mem_req_t             mem_req,
  input  logic [lsr_pkg::DATA_WIDTH-1:0] mem_rdata
);
  import lsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_REV_RD_HI, S_REV_WR_LO, S_REV_WR_HI
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      fill_r;
  logic [CNT_W-1:0]      cap_r;
  logic [AW-1:0]         lo_r;
  logic [AW-1:0]         hi_r;
  logic [DATA_WIDTH-1:0] tmp_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_pop_value_r;
  logic [1:0]            out_status_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  accept;
  logic [CNT_W-1:0]      limit;
  logic                  full;
  logic [CNT_W-1:0]      fill_m1;
  logic                  more_pairs;

  assign limit      = (cap_r > DEPTH_CNT) ? DEPTH_CNT : cap_r;
  assign full       = (fill_r >= limit);
  assign fill_m1    = fill_r - CNT_W'(1);
  assign accept     = in_valid && !in_stall;
  assign in_stall   = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign cfg_ready  = (state_r == S_IDLE);
  // another pair remains after (lo, hi) when lo + 1 < hi - 1
  assign more_pairs = ({1'b0, lo_r} + CNT_W'(2)) < {1'b0, hi_r};

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = in_push_value;
    case (state_r)
      S_IDLE: begin
        mem_req.raddr = (in_opcode == OP_POP) ? fill_m1[AW-1:0] : '0;
        mem_req.waddr = fill_r[AW-1:0];
        mem_req.we    = accept && (in_opcode == OP_PUSH) && !full;
      end
      S_REV_RD_HI: begin
        mem_req.raddr = hi_r;
      end
      S_REV_WR_LO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = lo_r;
        mem_req.wdata = mem_rdata;
      end
      S_REV_WR_HI: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hi_r;
        mem_req.wdata = tmp_r;
        mem_req.raddr = lo_r + AW'(1);
      end
      default: begin
        mem_req.raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= DEPTH_CNT;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_pop_value_r <= '0;
            out_status_r    <= STAT_OK;
            out_count_r     <= fill_r;
            out_valid_r     <= 1'b1;
            case (in_opcode)
              OP_PUSH: begin
                if (full) begin
                  out_status_r <= STAT_OVF;
                end else begin
                  fill_r      <= fill_r + CNT_W'(1);
                  out_count_r <= fill_r + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (fill_r == '0) begin
                  out_status_r    <= STAT_UDF;
                  out_pop_value_r <= '1;
                end else begin
                  // result leaves once the read data is back
                  fill_r      <= fill_m1;
                  out_valid_r <= 1'b0;
                  state_r     <= S_POP;
                end
              end
              OP_REV: begin
                if (fill_r > CNT_W'(1)) begin
                  lo_r    <= '0;
                  hi_r    <= fill_m1[AW-1:0];
                  state_r <= S_REV_RD_HI;
                end
              end
              default: begin
                out_status_r <= STAT_OK;
              end
            endcase
          end
        end
        S_POP: begin
          out_pop_value_r <= mem_rdata;
          out_status_r    <= STAT_OK;
          out_count_r     <= fill_r;
          out_valid_r     <= 1'b1;
          state_r         <= S_IDLE;
        end
        S_REV_RD_HI: begin
          tmp_r   <= mem_rdata;
          state_r <= S_REV_WR_LO;
        end
        S_REV_WR_LO: begin
          state_r <= S_REV_WR_HI;
        end
        S_REV_WR_HI: begin
          lo_r    <= lo_r + AW'(1);
          hi_r    <= hi_r - AW'(1);
          state_r <= more_pairs ? S_REV_RD_HI : S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;

endmodule

### src/lifo_stack_with_reverse.sv
// Push, reverse, no-op: result in the cycle after the request; pop first passes S_POP.
// Throughput: one push per cycle while no result is stalled; pop holds off input for its RAM read.
// Reverse holds off input in states S_REV_RD_HI, S_REV_WR_LO and S_REV_WR_HI for each of
// floor(count/2) swapped pairs, on the single read and single write port of the entry RAM.
// Reset (rst_n low, synchronous): stack empty, capacity 64, no result pending.
module lifo_stack_with_reverse (
  input  logic                           clk,
  input  logic                           rst_n,
  // command requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [lsr_pkg::DATA_WIDTH-1:0] in_push_value,
  // capacity register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsr_pkg::CNT_W-1:0]      cfg_capacity,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lsr_pkg::DATA_WIDTH-1:0] out_pop_value,
  output logic [1:0]                     out_status,
  output logic [lsr_pkg::CNT_W-1:0]      out_count
);
  import lsr_pkg::*;

  // Controller <-> entry RAM. The controller owns the fill count and the
  // capacity register; the RAM holds only the words. Reverse is a swap walk
  // from both ends: read lo, read hi, write lo, write hi (with the next lo
  // read issued in that same cycle). No two accesses to one entry overlap, so
  // no forwarding is needed.
  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;

  lsr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_count     (out_count),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // Entries are not cleared: only data from slots below the fill count is used.
  lsr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

### src/lsr_checker.sv
`include "lifo_stack_with_reverse_defines.svh"

module lsr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lsr_pkg::DATA_WIDTH-1:0] out_pop_value,
  input logic [1:0]                     out_status,
  input logic [lsr_pkg::CNT_W-1:0]      out_count
);
  import lsr_pkg::*;

  logic [DATA_WIDTH+CNT_W+1:0] out_res;

  assign out_res = {out_pop_value, out_status, out_count};

  `LSR_ASSERT_NOW(a_count_bound, out_valid, out_count <= DEPTH_CNT, "count above depth")
  `LSR_ASSERT_NOW(a_ovf_value, out_valid && out_status == STAT_OVF, ~|out_pop_value, "ovf value")
  `LSR_ASSERT_NOW(a_udf_value, out_valid && out_status == STAT_UDF, &out_pop_value, "udf value")
  `LSR_ASSERT_NOW(a_udf_count, out_valid && out_status == STAT_UDF, out_count == '0, "udf count")
  `LSR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_res), "result not held")

endmodule

bind lifo_stack_with_reverse lsr_checker u_lsr_checker (.*);
